// ----- hdl/stsp_pkg.sv -----
// ----------------------------------------------------------------------------
// stsp_pkg: shared types and constants of the semantic token span painter
// Holds the controller states, the command and status groups between the
// controller and the datapath, register indexes and the type color table.
// ----------------------------------------------------------------------------
package stsp_pkg;

  localparam int unsigned LineW  = 16;
  localparam int unsigned LenW   = 7;
  localparam int unsigned TypeW  = 5;
  localparam int unsigned ColW   = 18;  // signed screen column while painting
  localparam int unsigned ColorW = 24;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_FIRST_LINE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAST_LINE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COL_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // take a token word and advance the sums
    logic set_past;   // token fell below the window: stop the set
    logic start_run;  // prime the character run
    logic step;       // paint one character
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic past;       // set stopped earlier
    logic above;      // token line above the window
    logic below;      // token line below the window
    logic empty;      // zero length token
    logic out_free;   // output register can take a word this cycle
    logic last_char;  // current character is the last of the token
  } sts_t;

  function automatic logic [ColorW-1:0] type_color(input logic [TypeW-1:0] t);
    logic [ColorW-1:0] c;
    unique case (t)
      5'd0, 5'd1, 5'd7:          c = {8'd114, 8'd216, 8'd249};
      5'd2, 5'd6, 5'd15, 5'd17:  c = {8'd127, 8'd65,  8'd99};
      5'd3, 5'd5:                c = {8'd250, 8'd187, 8'd134};
      5'd4:                      c = {8'd255, 8'd224, 8'd175};
      5'd8:                      c = {8'd98,  8'd130, 8'd160};
      5'd9:                      c = {8'd182, 8'd224, 8'd246};
      5'd10, 5'd11:              c = {8'd244, 8'd125, 8'd117};
      5'd12, 5'd13, 5'd18:       c = {8'd184, 8'd91,  8'd106};
      5'd14, 5'd20, 5'd21, 5'd22: c = {8'd240, 8'd240, 8'd240};
      5'd16, 5'd19:              c = {8'd213, 8'd180, 8'd197};
      5'd23, 5'd24:              c = {8'd205, 8'd254, 8'd185};
      default:                   c = '0;  // unnamed types paint black
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/stsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// stsp_ctrl: token sequencer
// Takes one token word, checks it against the window, then steps the
// datapath through its characters one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module stsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stsp_pkg::sts_t sts_i,
  output stsp_pkg::cmd_t cmd_o
);

  stsp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stsp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stsp_pkg::ST_CHECK;
        end
      end
      stsp_pkg::ST_CHECK: begin
        state_d = stsp_pkg::ST_IDLE;
        if (sts_i.past || sts_i.above) begin
          state_d = stsp_pkg::ST_IDLE;
        end else if (sts_i.below) begin
          cmd_o.set_past = 1'b1;
        end else if (!sts_i.empty) begin
          cmd_o.start_run = 1'b1;
          state_d         = stsp_pkg::ST_RUN;
        end
      end
      stsp_pkg::ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last_char) begin
            state_d = stsp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = stsp_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> sts_i.out_free)
    else $error("step issued while output register is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("new token taken before the previous one was checked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_run |-> !sts_i.empty && !sts_i.past)
    else $error("run started for a token that paints nothing");

endmodule

// ----- hdl/stsp_dpath.sv -----
// ----------------------------------------------------------------------------
// stsp_dpath: sums, window registers and character painter
// Keeps the running line and column sums, the window configuration and the
// per-token run registers, and drives the output register.
// ----------------------------------------------------------------------------
module stsp_dpath #(
  parameter int unsigned MAX_TOKEN_LENGTH = 64,
  parameter int unsigned LEFT_MARGIN      = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stsp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [stsp_pkg::LineW-1:0]      cfg_data_i,
  input  logic                            start_of_set_i,
  input  logic [stsp_pkg::LineW-1:0]      line_delta_i,
  input  logic [stsp_pkg::LineW-1:0]      char_delta_i,
  input  logic [stsp_pkg::LenW-1:0]       token_length_i,
  input  logic [stsp_pkg::TypeW-1:0]      token_type_i,
  input  stsp_pkg::cmd_t                  cmd_i,
  output stsp_pkg::sts_t                  sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [stsp_pkg::LineW-1:0]      screen_column_o,
  output logic [stsp_pkg::LineW-1:0]      screen_row_o,
  output logic [stsp_pkg::ColorW-1:0]     color_o,
  output logic                            last_of_run_o
);

  localparam int unsigned LW = stsp_pkg::LineW;
  localparam int unsigned CW = stsp_pkg::ColW;
  localparam logic [stsp_pkg::LenW-1:0] MaxLen = stsp_pkg::LenW'(MAX_TOKEN_LENGTH);
  localparam logic signed [CW-1:0] Margin = CW'(LEFT_MARGIN);
  localparam logic signed [CW-1:0] ColMax = CW'((1 << LW) - 1);

  logic [LW-1:0] first_q, last_q, offset_q;
  logic [LW-1:0] line_sum_q, line_sum_d, column_sum_q, column_sum_d;
  logic          past_q, past_d;
  logic [stsp_pkg::LenW-1:0]  len_q, cnt_q, cnt_d;
  logic [stsp_pkg::TypeW-1:0] type_q;
  logic signed [CW-1:0] col_q, col_d;
  logic [LW-1:0] row_q;
  logic          out_valid_q;
  logic [LW-1:0] out_col_q, out_row_q;
  logic [stsp_pkg::ColorW-1:0] out_color_q;
  logic          out_last_q;
  logic          eff_past, visible;
  logic [LW-1:0] line_base, col_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      last_q   <= '1;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stsp_pkg::CFG_FIRST_LINE: first_q  <= cfg_data_i;
        stsp_pkg::CFG_LAST_LINE:  last_q   <= cfg_data_i;
        stsp_pkg::CFG_COL_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sum and stop flag update on token load and on set stop.
  always_comb begin
    eff_past     = past_q && !start_of_set_i;
    line_base    = start_of_set_i ? '0 : line_sum_q;
    col_base     = start_of_set_i ? '0 : column_sum_q;
    line_sum_d   = line_sum_q;
    column_sum_d = column_sum_q;
    past_d       = past_q;
    if (cmd_i.load) begin
      past_d = eff_past;
      if (start_of_set_i) begin
        line_sum_d   = '0;
        column_sum_d = '0;
      end
      if (!eff_past) begin
        line_sum_d   = line_base + line_delta_i;
        column_sum_d = (line_delta_i == '0) ? col_base + char_delta_i : char_delta_i;
      end
    end else if (cmd_i.set_past) begin
      past_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_sum_q   <= '0;
      column_sum_q <= '0;
      past_q       <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      line_sum_q   <= line_sum_d;
      column_sum_q <= column_sum_d;
      past_q       <= past_d;
      cnt_q        <= cnt_d;
      if (cmd_i.step && visible) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Run registers.
  always_comb begin
    cnt_d = cnt_q;
    col_d = col_q;
    if (cmd_i.start_run) begin
      cnt_d = (len_q > MaxLen) ? MaxLen : len_q;
      col_d = $signed({2'b00, column_sum_q}) + Margin - $signed({2'b00, offset_q});
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - 1'b1;
      col_d = col_q + 2'sd1;
    end
  end

  assign visible = (col_q >= Margin) && (col_q <= ColMax);

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    if (cmd_i.load) begin
      len_q  <= token_length_i;
      type_q <= token_type_i;
    end
    if (cmd_i.start_run) begin
      row_q <= line_sum_q - first_q;
    end
    if (cmd_i.step && visible) begin
      out_col_q   <= col_q[LW-1:0];
      out_row_q   <= row_q;
      out_color_q <= stsp_pkg::type_color(type_q);
      out_last_q  <= (cnt_q == stsp_pkg::LenW'(1)) || (col_q == ColMax);
    end
  end

  always_comb begin
    sts_o.past      = past_q;
    sts_o.above     = line_sum_q < first_q;
    sts_o.below     = line_sum_q > last_q;
    sts_o.empty     = (len_q == '0);
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.last_char = (cnt_q == stsp_pkg::LenW'(1));
  end

  assign out_valid_o     = out_valid_q;
  assign screen_column_o = out_col_q;
  assign screen_row_o    = out_row_q;
  assign color_o         = out_color_q;
  assign last_of_run_o   = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> cnt_q != '0)
    else $error("character step with no characters left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.step))
    else $error("output word appeared without a character step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_past |-> sts_o.below && !sts_o.above)
    else $error("set stopped for a token inside the window");

endmodule

// ----- hdl/semantic_token_span_painter.sv -----
// ----------------------------------------------------------------------------
// semantic_token_span_painter: delta-coded semantic tokens to color writes
// Decodes a token stream into one screen write per visible character.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one token per word. tuser carries start_of_set, which
//   clears the line and column sums and the stop flag before the token.
//   Master channel: one word per painted character; tlast marks the final
//   write of a token. Tokens that paint nothing produce no words.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 first shown line, 1 last shown line, 2 column offset); write only
//   while no token is in flight.
// Timing:
//   A token is taken, then checked against the window in the cycle after;
//   a visible token then paints one character per cycle while the
//   master channel takes its words. The single character counter and
//   column incrementer set that rate.
//   A visible first character reaches the master channel through the check
//   state, the run start and the output register.
// Reset: sums, stop flag and output valid clear; window spans all lines.
// Stall: a held output word stalls the character run; the next token may
//   be taken while the final word of the previous one still waits.
// ----------------------------------------------------------------------------
module semantic_token_span_painter #(
  parameter int unsigned MAX_TOKEN_LENGTH = 64,
  parameter int unsigned LEFT_MARGIN      = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // token input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] line_delta, [31:16] char_delta, [38:32] token_length,
  // [43:39] token_type, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  // [0] start_of_set
  input  logic        s_axis_tuser,
  // character writes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] screen_column, [31:16] screen_row, [39:32] red,
  // [47:40] green, [55:48] blue
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  stsp_pkg::cmd_t cmd;
  stsp_pkg::sts_t sts;
  logic [15:0] screen_column, screen_row;
  logic [23:0] color;

  stsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stsp_dpath #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
    .LEFT_MARGIN      (LEFT_MARGIN)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .start_of_set_i  (s_axis_tuser),
    .line_delta_i    (s_axis_tdata[15:0]),
    .char_delta_i    (s_axis_tdata[31:16]),
    .token_length_i  (s_axis_tdata[38:32]),
    .token_type_i    (s_axis_tdata[43:39]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .screen_column_o (screen_column),
    .screen_row_o    (screen_row),
    .color_o         (color),
    .last_of_run_o   (m_axis_tlast)
  );

  // color is {red, green, blue}; pack red lowest
  assign m_axis_tdata = {color[7:0], color[15:8], color[23:16], screen_row, screen_column};

endmodule
